/* src/i8vtp_pkg.sv */
// i8vtp_pkg: result kinds, error codes and character codes for the int8 vector text parser
// no dependencies

package i8vtp_pkg;

  localparam int unsigned CountWidth = 15;
  localparam int unsigned MagWidth   = 8;

  typedef enum logic [1:0] {
    KIND_ELEMENT  = 2'd0,
    KIND_ACCEPTED = 2'd1,
    KIND_REJECTED = 2'd2
  } result_kind_t;

  typedef enum logic [2:0] {
    ERR_NONE      = 3'd0,
    ERR_SYNTAX    = 3'd1,
    ERR_EMPTY     = 3'd2,
    ERR_TOO_MANY  = 3'd3,
    ERR_NOT_INT   = 3'd4,
    ERR_RANGE     = 3'd5,
    ERR_JUNK      = 3'd6,
    ERR_DIMS      = 3'd7
  } error_code_t;

  localparam logic [7:0] CharNul    = 8'd0;
  localparam logic [7:0] CharOpen   = 8'd91;
  localparam logic [7:0] CharClose  = 8'd93;
  localparam logic [7:0] CharComma  = 8'd44;
  localparam logic [7:0] CharPoint  = 8'd46;
  localparam logic [7:0] CharExpLo  = 8'd101;
  localparam logic [7:0] CharExpUp  = 8'd69;
  localparam logic [7:0] CharPlus   = 8'd43;
  localparam logic [7:0] CharMinus  = 8'd45;
  localparam logic [7:0] CharZero   = 8'd48;
  localparam logic [7:0] CharNine   = 8'd57;

  localparam logic [MagWidth-1:0] MagSaturate = 8'd255;
  localparam logic [MagWidth-1:0] PosLimit    = 8'd127;
  localparam logic [MagWidth-1:0] NegLimit    = 8'd128;

  function automatic logic is_blank(input logic [7:0] c);
    return c == 8'd32 || c == 8'd9 || c == 8'd10 || c == 8'd13 || c == 8'd11 || c == 8'd12;
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return c >= CharZero && c <= CharNine;
  endfunction

endpackage

/* src/int8_vector_text_parser.sv */
// int8_vector_text_parser: parses "[1,-2, +3]" style int8 vector text, one byte per transfer
// depends on i8vtp_pkg
//
//   channel   signals                       holds
//   s         s_tvalid s_tready s_tdata     text byte, 0 ends the string
//   m         m_tvalid m_tready m_tdata     element, count, error code
//             m_tuser                       result kind
//   cfg       cfg_we cfg_wdata              expected element count, 0 for any
//
// one byte per cycle while s_tready is high; a byte's result appears in the output register on the next cycle
// the phase update is a single pass of compare and multiply-by-ten logic
// a held result stalls input only while m_tready is low
// rst clears the phase, count and expected count to zero

module int8_vector_text_parser #(
  parameter int unsigned MAX_DIMS = 16384
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             s_tvalid,
  output logic                             s_tready,
  input  logic [7:0]                       s_tdata,   // text_byte
  output logic                             m_tvalid,
  input  logic                             m_tready,
  output logic [31:0]                      m_tdata,   // element_value, element_count, error_code
  output logic [1:0]                       m_tuser,   // result_kind
  input  logic                             cfg_we,
  input  logic [i8vtp_pkg::CountWidth-1:0] cfg_wdata
);

  import i8vtp_pkg::*;

  typedef enum logic [2:0] {
    PH_OPEN, PH_FIRST, PH_ELEM, PH_SIGN, PH_DIGITS, PH_AFTER, PH_TAIL, PH_DRAIN
  } phase_t;

  localparam logic [CountWidth-1:0] MaxCount = CountWidth'(MAX_DIMS);

  phase_t                phase, phase_next;
  logic [CountWidth-1:0] parsed_count, parsed_count_next;
  logic [MagWidth-1:0]   digit_magnitude, digit_magnitude_next;
  logic                  minus_seen, minus_seen_next;
  logic [CountWidth-1:0] expected_dims;

  logic                  emit;
  result_kind_t          kind_next;
  logic [7:0]            value_next;
  logic [CountWidth-1:0] count_out_next;
  error_code_t           err_next;
  logic                  rej;
  error_code_t           rej_err;

  result_kind_t          result_kind;
  logic [7:0]            element_value;
  logic [CountWidth-1:0] element_count;
  error_code_t           error_code;

  logic                  take;
  logic [7:0]            c;
  logic [11:0]           mag_grown;
  logic [MagWidth-1:0]   limit;

  assign s_tready = !m_tvalid || m_tready;
  assign take     = s_tvalid && s_tready;
  assign c        = s_tdata;
  assign mag_grown = {digit_magnitude, 3'b000} + {3'b000, digit_magnitude, 1'b0}
                   + {4'b0000, c - CharZero};
  assign limit    = minus_seen ? NegLimit : PosLimit;

  always_comb begin
    phase_next           = phase;
    parsed_count_next    = parsed_count;
    digit_magnitude_next = digit_magnitude;
    minus_seen_next      = minus_seen;
    emit                 = 1'b0;
    kind_next            = KIND_ELEMENT;
    value_next           = '0;
    count_out_next       = parsed_count;
    err_next             = ERR_NONE;
    rej                  = 1'b0;
    rej_err              = ERR_SYNTAX;

    unique case (phase)
      PH_OPEN: begin
        if (!is_blank(c)) begin
          if (c == CharOpen) phase_next = PH_FIRST;
          else rej = 1'b1;
        end
      end
      PH_FIRST, PH_ELEM: begin
        if (phase == PH_ELEM && parsed_count >= MaxCount) begin
          rej     = 1'b1;
          rej_err = ERR_TOO_MANY;
        end else if (is_blank(c)) begin
          phase_next = phase;
        end else if (phase == PH_FIRST && c == CharClose) begin
          rej     = 1'b1;
          rej_err = ERR_EMPTY;
        end else begin
          digit_magnitude_next = '0;
          minus_seen_next      = 1'b0;
          if (c == CharPlus || c == CharMinus) begin
            minus_seen_next = (c == CharMinus);
            phase_next      = PH_SIGN;
          end else if (is_digit(c)) begin
            digit_magnitude_next = c - CharZero;
            phase_next           = PH_DIGITS;
          end else begin
            rej = 1'b1;
          end
        end
      end
      PH_SIGN: begin
        if (is_digit(c)) begin
          digit_magnitude_next = c - CharZero;
          phase_next           = PH_DIGITS;
        end else begin
          rej = 1'b1;
        end
      end
      PH_DIGITS: begin
        if (is_digit(c)) begin
          digit_magnitude_next = (mag_grown > 12'(MagSaturate)) ? MagSaturate
                                                                 : mag_grown[MagWidth-1:0];
        end else if (c == CharPoint || c == CharExpLo || c == CharExpUp) begin
          rej     = 1'b1;
          rej_err = ERR_NOT_INT;
        end else if (digit_magnitude > limit) begin
          rej     = 1'b1;
          rej_err = ERR_RANGE;
        end else if (is_blank(c) || c == CharComma || c == CharClose) begin
          if (is_blank(c))          phase_next = PH_AFTER;
          else if (c == CharComma)  phase_next = PH_ELEM;
          else                      phase_next = PH_TAIL;
          emit                 = 1'b1;
          kind_next            = KIND_ELEMENT;
          value_next           = minus_seen ? 8'(8'd0 - digit_magnitude) : digit_magnitude;
          parsed_count_next    = parsed_count + 1'b1;
          count_out_next       = parsed_count + 1'b1;
          digit_magnitude_next = '0;
          minus_seen_next      = 1'b0;
        end else begin
          rej = 1'b1;
        end
      end
      PH_AFTER: begin
        if (!is_blank(c)) begin
          if (c == CharComma)      phase_next = PH_ELEM;
          else if (c == CharClose) phase_next = PH_TAIL;
          else                     rej = 1'b1;
        end
      end
      PH_TAIL: begin
        if (!is_blank(c)) begin
          if (c != CharNul) begin
            rej     = 1'b1;
            rej_err = ERR_JUNK;
          end else if (expected_dims != '0 && expected_dims != parsed_count) begin
            rej     = 1'b1;
            rej_err = ERR_DIMS;
          end else begin
            emit                 = 1'b1;
            kind_next            = KIND_ACCEPTED;
            phase_next           = PH_OPEN;
            parsed_count_next    = '0;
            digit_magnitude_next = '0;
            minus_seen_next      = 1'b0;
          end
        end
      end
      default: begin
        if (c == CharNul) begin
          phase_next           = PH_OPEN;
          parsed_count_next    = '0;
          digit_magnitude_next = '0;
          minus_seen_next      = 1'b0;
        end
      end
    endcase

    if (rej) begin
      emit           = 1'b1;
      kind_next      = KIND_REJECTED;
      value_next     = '0;
      count_out_next = parsed_count;
      err_next       = rej_err;
      if (c == CharNul) begin
        phase_next           = PH_OPEN;
        parsed_count_next    = '0;
        digit_magnitude_next = '0;
        minus_seen_next      = 1'b0;
      end else begin
        phase_next = PH_DRAIN;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase           <= PH_OPEN;
      parsed_count    <= '0;
      digit_magnitude <= '0;
      minus_seen      <= 1'b0;
      expected_dims   <= '0;
      m_tvalid        <= 1'b0;
      result_kind     <= KIND_ELEMENT;
      element_value   <= '0;
      element_count   <= '0;
      error_code      <= ERR_NONE;
    end else begin
      if (cfg_we) expected_dims <= cfg_wdata;
      if (take) begin
        phase           <= phase_next;
        parsed_count    <= parsed_count_next;
        digit_magnitude <= digit_magnitude_next;
        minus_seen      <= minus_seen_next;
      end
      if (s_tready) m_tvalid <= take && emit;
      if (take && emit) begin
        result_kind   <= kind_next;
        element_value <= value_next;
        element_count <= count_out_next;
        error_code    <= err_next;
      end
    end
  end

  assign m_tdata = {6'b000000, error_code, element_count, element_value};
  assign m_tuser = result_kind;

endmodule

/* test/testbench.sv */
// testbench for int8_vector_text_parser: directed and random bracketed text streamed
// byte by byte, each result compared against an in-bench parse of the same bytes
// depends on i8vtp_pkg and int8_vector_text_parser

`timescale 1ns / 1ps

module testbench;
  import i8vtp_pkg::*;

  localparam int unsigned MaxElems     = 16384;
  localparam int          CycleLimit   = 1000000;
  localparam int          SettleCycles = 4;

  typedef enum logic [2:0] {
    P_OPEN, P_FIRST, P_ELEM, P_SIGN, P_DIGITS, P_AFTER, P_TAIL, P_DRAIN
  } text_phase_t;

  typedef struct packed {
    result_kind_t          kind;
    logic [7:0]            value;
    logic [CountWidth-1:0] count;
    error_code_t           err;
  } parse_result_t;

  logic                  clk;
  logic                  rst;
  logic                  s_tvalid;
  logic                  s_tready;
  logic [7:0]            s_tdata;   // text_byte
  logic                  m_tvalid;
  logic                  m_tready;
  logic [31:0]           m_tdata;   // element_value, element_count, error_code
  logic [1:0]            m_tuser;   // result_kind
  logic                  cfg_we;
  logic [CountWidth-1:0] cfg_wdata;

  parse_result_t         results_due[$];
  text_phase_t           phase;
  logic [CountWidth-1:0] elem_count;
  logic [CountWidth-1:0] dims_required;
  int unsigned           magnitude;
  bit                    negative;
  bit                    steady;
  int                    faults;
  int                    cycles;
  int                    bytes_sent;
  int                    strings_sent;
  int                    results_checked;

  int8_vector_text_parser #(
    .MAX_DIMS(MaxElems)
  ) uut (
    .clk(clk),
    .rst(rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata(s_tdata),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata(m_tdata),
    .m_tuser(m_tuser),
    .cfg_we(cfg_we),
    .cfg_wdata(cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles >= CycleLimit) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycles, results_due.size());
      $display("TB_ERROR");
      $finish;
    end
  end

  always @(negedge clk) begin
    m_tready <= steady || ($urandom_range(99) >= 22);
  end

  // parse model

  function automatic bit blank_char(input logic [7:0] c);
    return c inside {8'd32, 8'd9, 8'd10, 8'd11, 8'd12, 8'd13};
  endfunction

  function automatic bit digit_char(input logic [7:0] c);
    return c >= CharZero && c <= CharNine;
  endfunction

  function automatic void clear_text_state();
    phase = P_OPEN;
    elem_count = '0;
    magnitude = 0;
    negative = 1'b0;
  endfunction

  function automatic void post_result(input result_kind_t kind, input logic [7:0] value,
                                      input logic [CountWidth-1:0] count, input error_code_t err);
    parse_result_t r;
    r.kind = kind;
    r.value = value;
    r.count = count;
    r.err = err;
    results_due.push_back(r);
  endfunction

  function automatic void fail_string(input logic [7:0] c, input error_code_t err);
    post_result(KIND_REJECTED, 8'd0, elem_count, err);
    if (c == CharNul) clear_text_state();
    else phase = P_DRAIN;
  endfunction

  function automatic void open_element(input logic [7:0] c);
    magnitude = 0;
    negative = 1'b0;
    if (c == CharPlus || c == CharMinus) begin
      negative = (c == CharMinus);
      phase = P_SIGN;
    end else if (digit_char(c)) begin
      magnitude = 32'(c - CharZero);
      phase = P_DIGITS;
    end else begin
      fail_string(c, ERR_SYNTAX);
    end
  endfunction

  function automatic void advance_parse(input logic [7:0] c);
    int unsigned grown;
    case (phase)
      P_OPEN: begin
        if (c == CharOpen) phase = P_FIRST;
        else if (!blank_char(c)) fail_string(c, ERR_SYNTAX);
      end
      P_FIRST: begin
        if (c == CharClose) fail_string(c, ERR_EMPTY);
        else if (!blank_char(c)) open_element(c);
      end
      P_ELEM: begin
        if (elem_count >= MaxElems) fail_string(c, ERR_TOO_MANY);
        else if (!blank_char(c)) open_element(c);
      end
      P_SIGN: begin
        if (digit_char(c)) begin
          magnitude = 32'(c - CharZero);
          phase = P_DIGITS;
        end else begin
          fail_string(c, ERR_SYNTAX);
        end
      end
      P_DIGITS: begin
        if (digit_char(c)) begin
          grown = magnitude * 10 + (c - CharZero);
          magnitude = (grown > 255) ? 255 : grown;
        end else if (c inside {CharPoint, CharExpLo, CharExpUp}) begin
          fail_string(c, ERR_NOT_INT);
        end else if (magnitude > (negative ? 128 : 127)) begin
          fail_string(c, ERR_RANGE);
        end else if (!(blank_char(c) || c == CharComma || c == CharClose)) begin
          fail_string(c, ERR_SYNTAX);
        end else begin
          phase = blank_char(c) ? P_AFTER : (c == CharComma) ? P_ELEM : P_TAIL;
          elem_count = elem_count + 1'b1;
          post_result(KIND_ELEMENT, negative ? 8'(256 - magnitude) : 8'(magnitude),
                      elem_count, ERR_NONE);
          magnitude = 0;
          negative = 1'b0;
        end
      end
      P_AFTER: begin
        if (c == CharComma) phase = P_ELEM;
        else if (c == CharClose) phase = P_TAIL;
        else if (!blank_char(c)) fail_string(c, ERR_SYNTAX);
      end
      P_TAIL: begin
        if (blank_char(c)) begin
        end else if (c != CharNul) begin
          fail_string(c, ERR_JUNK);
        end else if (dims_required != 0 && dims_required != elem_count) begin
          fail_string(c, ERR_DIMS);
        end else begin
          post_result(KIND_ACCEPTED, 8'd0, elem_count, ERR_NONE);
          clear_text_state();
        end
      end
      default: begin
        if (c == CharNul) clear_text_state();
      end
    endcase
  endfunction

  // result checking

  task automatic report_fault(input string msg);
    faults++;
    $display("mismatch at cycle %0d: %s", cycles, msg);
  endtask

  always @(posedge clk) begin : check_results
    parse_result_t want;
    if (!rst && m_tvalid && m_tready) begin
      results_checked++;
      if (results_due.size() == 0) begin
        report_fault($sformatf("result with none expected, kind %0d", m_tuser));
      end else begin
        want = results_due.pop_front();
        if (m_tuser !== want.kind)
          report_fault($sformatf("kind %0d, expected %0d", m_tuser, want.kind));
        if (m_tdata[7:0] !== want.value)
          report_fault($sformatf("value %0d, expected %0d", m_tdata[7:0], want.value));
        if (m_tdata[22:8] !== want.count)
          report_fault($sformatf("count %0d, expected %0d", m_tdata[22:8], want.count));
        if (m_tdata[25:23] !== want.err)
          report_fault($sformatf("error %0d, expected %0d", m_tdata[25:23], want.err));
      end
    end
  end

  // stimulus helpers

  task automatic send_byte(input logic [7:0] c);
    int gap;
    @(negedge clk);
    gap = (!steady && $urandom_range(99) < 22) ? $urandom_range(3, 1) : 0;
    if (gap != 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= c;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    advance_parse(c);
    bytes_sent++;
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_byte(s[i]);
    send_byte(CharNul);
    strings_sent++;
  endtask

  task automatic drain_results();
    @(negedge clk);
    s_tvalid <= 1'b0;
    while (results_due.size() != 0) @(posedge clk);
    repeat (SettleCycles) @(posedge clk);
  endtask

  task automatic set_expected_dims(input logic [CountWidth-1:0] dims);
    drain_results();
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= dims;
    @(negedge clk);
    cfg_we <= 1'b0;
    dims_required = dims;
  endtask

  function automatic logic [7:0] pick_blank();
    case ($urandom_range(5))
      0: return 8'd9;
      1: return 8'd10;
      2: return 8'd11;
      3: return 8'd12;
      4: return 8'd13;
      default: return 8'd32;
    endcase
  endfunction

  function automatic logic [7:0] pick_stray();
    case ($urandom_range(8))
      0: return CharPoint;
      1: return CharExpLo;
      2: return CharExpUp;
      3: return CharComma;
      4: return CharClose;
      5: return CharOpen;
      6: return CharPlus;
      7: return CharMinus;
      default: return 8'd120;
    endcase
  endfunction

  function automatic void add_blanks(ref logic [7:0] text[$]);
    int n = ($urandom_range(99) < 35) ? $urandom_range(2, 1) : 0;
    repeat (n) text.push_back(pick_blank());
  endfunction

  // mostly well-formed vectors, some with one byte broken, dropped or inserted
  task automatic send_random_vector(input int max_elems);
    logic [7:0] text[$];
    string digits;
    int n, mag, pos, roll;
    n = ($urandom_range(99) < 3) ? 0 : $urandom_range(max_elems, 1);
    add_blanks(text);
    text.push_back(CharOpen);
    if (n == 0) begin
      add_blanks(text);
      text.push_back(CharClose);
    end
    for (int i = 0; i < n; i++) begin
      add_blanks(text);
      roll = $urandom_range(2);
      if (roll == 1) text.push_back(CharPlus);
      else if (roll == 2) text.push_back(CharMinus);
      mag = ($urandom_range(99) < 10) ? $urandom_range(999) : $urandom_range(128);
      if ($urandom_range(99) < 8) text.push_back(CharZero);
      digits = $sformatf("%0d", mag);
      for (int k = 0; k < digits.len(); k++) text.push_back(digits[k]);
      add_blanks(text);
      text.push_back((i == n - 1) ? CharClose : CharComma);
    end
    add_blanks(text);
    roll = $urandom_range(99);
    pos = $urandom_range(text.size() - 1);
    if (roll >= 92) text.delete(pos);
    else if (roll >= 85) text.insert(pos, pick_stray());
    else if (roll >= 70) text[pos] = 8'($urandom_range(255));
    text.push_back(CharNul);
    foreach (text[k]) send_byte(text[k]);
    strings_sent++;
  endtask

  task automatic send_noise();
    int len;
    len = $urandom_range(12, 1);
    if ($urandom_range(1)) send_byte(CharOpen);
    repeat (len) begin
      if ($urandom_range(1)) send_byte(8'($urandom_range(CharNine, CharZero)));
      else if ($urandom_range(1)) send_byte(pick_stray());
      else send_byte(8'($urandom_range(255, 1)));
    end
    send_byte(CharNul);
    strings_sent++;
  endtask

  // tests

  task automatic test_well_formed();
    send_text("\t[ \n127\013,\014-128\015, +0 ]  ");
    send_text("[+5,-0,007]");
    send_text("[ 12 , 3 ]");
  endtask

  task automatic test_rejections();
    send_text("[]");
    send_text("[-]");
    send_text("[1.5]");
    send_text("[1e2]");
    send_text("[2E]");
    send_text("[.5]");
    send_text("[999]");
    send_text("[128]");
    send_text("[-129]");
    send_text("[300x");
    send_text("[5x]");
    send_text("[1]x");
    send_text("[1,,2]");
    send_text("[1 2]");
    send_text("x[1]");
    send_byte(CharNul);
    send_byte(8'd255);
    send_byte(CharNul);
    send_text("[1]");
  endtask

  task automatic test_expected_count();
    set_expected_dims(CountWidth'(2));
    send_text("[1,2]");
    send_text("[1]");
    send_text("[1,2,3]");
    send_text("[4,5]x");
    set_expected_dims('0);
  endtask

  task automatic test_random();
    logic [CountWidth-1:0] dims;
    int goal, strings_in_phase;
    for (int p = 0; p < 5; p++) begin
      case (p)
        1: dims = CountWidth'(3);
        2: dims = CountWidth'(1);
        3: dims = CountWidth'(16383);
        default: dims = '0;
      endcase
      set_expected_dims(dims);
      steady = (p == 1);
      goal = bytes_sent + 280;
      strings_in_phase = 0;
      while (bytes_sent < goal) begin
        if ($urandom_range(99) < 10) send_noise();
        else send_random_vector((p == 2) ? 2 : 5);
        strings_in_phase++;
        if (strings_in_phase % 25 == 0) drain_results();
      end
    end
    steady = 1'b0;
  endtask

  initial begin
    rst = 1'b1;
    s_tvalid = 1'b0;
    s_tdata = '0;
    m_tready = 1'b0;
    cfg_we = 1'b0;
    cfg_wdata = '0;
    steady = 1'b0;
    dims_required = '0;
    clear_text_state();
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_well_formed();
    test_rejections();
    test_expected_count();
    test_random();

    drain_results();
    if (results_due.size() != 0)
      report_fault($sformatf("%0d results never arrived", results_due.size()));
    $display("sent %0d strings in %0d bytes, checked %0d results, %0d mismatches",
             strings_sent, bytes_sent, results_checked, faults);
    $display("covered well-formed, malformed and noisy text, expected counts 0 to 3 and 16383");
    if (faults == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

/* sim.f */
src/i8vtp_pkg.sv
src/int8_vector_text_parser.sv
test/testbench.sv
